// ===== src/lbm_pkg.sv =====
// Shared types, codes and reset values for the lexer input buffer.
`default_nettype none

package lbm_pkg;

  // Default depth of the byte store.
  localparam int DEPTH_DEF = 4096;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_INIT_CAP  = 2'd0;
  localparam logic [1:0] CFG_GROW_STEP = 2'd1;
  localparam logic [1:0] CFG_GROW_MODE = 2'd2;

  // Growth modes; the unused code behaves as fixed.
  localparam logic [1:0] MODE_NOGROW = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_MUL    = 2'd2;

  // Register reset values.
  localparam int         CAP_RESET  = 256;
  localparam logic [7:0] STEP_RESET = 8'd16;
  localparam logic [1:0] MODE_RESET = MODE_ADD;

  typedef enum logic [2:0] {
    REQ_ADD,
    REQ_READ,
    REQ_RETRACT,
    REQ_MARK,
    REQ_RESTORE,
    REQ_RECOVER,
    REQ_CLEAR,
    REQ_PEEK
  } lbm_req_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic [12:0] position;
  } lbm_in_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  read_byte;
    logic        at_end;
    logic        is_full;
    logic        is_empty;
    logic [12:0] write_index;
    logic [12:0] read_index;
    logic [12:0] mark_index;
    logic [12:0] capacity_now;
  } lbm_out_t;

  typedef struct packed {
    logic        wr;
    logic [1:0]  index;
    logic [12:0] data;
  } lbm_cfg_t;

endpackage

`default_nettype wire

// ===== src/lbm_ctrl.sv =====
// Pointer, flag and capacity state of the lexer input buffer, with its update logic.
`default_nettype none

module lbm_ctrl #(
  parameter int MEM_DEPTH = lbm_pkg::DEPTH_DEF,
  parameter int ADDR_W    = $clog2(MEM_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc_i,
  input  wire lbm_pkg::lbm_in_t  in_i,
  input  wire lbm_pkg::lbm_cfg_t cfg_i,
  output lbm_pkg::lbm_out_t      res_o,
  output logic                   byte_sel_o,
  output logic                   mem_we_o,
  output logic [ADDR_W-1:0]      mem_waddr_o,
  output logic [7:0]             mem_wdata_o,
  output logic                   mem_re_o,
  output logic [ADDR_W-1:0]      mem_raddr_o
);
  import lbm_pkg::*;

  localparam int PTR_W   = $clog2(MEM_DEPTH + 1);
  localparam int PROD_W  = PTR_W + 8;
  localparam int CAP_RST = (CAP_RESET > MEM_DEPTH) ? MEM_DEPTH : CAP_RESET;

  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, mk_r, mk_nxt, cap_r, cap_nxt;
  logic             full_r, full_nxt, empty_r, empty_nxt, end_r, end_nxt;
  logic [7:0]       step_r, step_nxt;
  logic [1:0]       mode_r, mode_nxt;

  logic [31:0]       pos32, wp32, rp32, cfg32;
  logic [31:0]       wpo32, rpo32, mko32, capo32;
  logic [PROD_W-1:0] sum, prod, cand;
  logic              grow_ok, ok;
  logic [PTR_W-1:0]  cap_cfg;

  assign pos32 = 32'(in_i.position);
  assign wp32  = 32'(wp_r);
  assign rp32  = 32'(rp_r);
  assign cfg32 = 32'(cfg_i.data);

  // Candidate capacity for growth at the capacity limit.
  assign sum  = PROD_W'(cap_r) + PROD_W'(step_r);
  assign prod = PROD_W'(cap_r) * PROD_W'(step_r);
  assign cand = (mode_r == MODE_MUL) ? prod : sum;

  assign grow_ok = (step_r != 8'd0) && ((mode_r == MODE_ADD) || (mode_r == MODE_MUL)) &&
                   (cand > PROD_W'(cap_r)) && (cand <= PROD_W'(MEM_DEPTH)) &&
                   (wp32 < 32'(MEM_DEPTH));

  // A written capacity is held within one and the store depth.
  always_comb begin
    if (cfg_i.data == 13'd0) begin
      cap_cfg = PTR_W'(1);
    end else if (cfg32 > 32'(MEM_DEPTH)) begin
      cap_cfg = PTR_W'(MEM_DEPTH);
    end else begin
      cap_cfg = PTR_W'(cfg_i.data);
    end
  end

  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    mk_nxt      = mk_r;
    cap_nxt     = cap_r;
    full_nxt    = full_r;
    empty_nxt   = empty_r;
    end_nxt     = end_r;
    step_nxt    = step_r;
    mode_nxt    = mode_r;
    ok          = 1'b0;
    byte_sel_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = rp_r[ADDR_W-1:0];
    if (acc_i) begin
      case (lbm_req_t'(in_i.req_type))
        REQ_ADD: begin
          if (wp_r < cap_r) begin
            full_nxt = 1'b0;
            ok       = 1'b1;
          end else begin
            full_nxt = 1'b1;
            ok       = grow_ok;
            if (grow_ok) begin
              cap_nxt = cand[PTR_W-1:0];
            end
          end
          if (ok) begin
            empty_nxt = 1'b0;
            mem_we_o  = 1'b1;
            wp_nxt    = wp_r + 1'b1;
          end
        end
        REQ_READ: begin
          if ((rp_r == wp_r) || (rp32 >= 32'(MEM_DEPTH))) begin
            end_nxt = 1'b1;
          end else begin
            end_nxt    = 1'b0;
            mem_re_o   = 1'b1;
            byte_sel_o = 1'b1;
            rp_nxt     = rp_r + 1'b1;
            ok         = 1'b1;
          end
        end
        REQ_RETRACT: begin
          if (rp_r != '0) begin
            rp_nxt = rp_r - 1'b1;
            ok     = 1'b1;
          end
        end
        REQ_MARK: begin
          if (pos32 <= wp32) begin
            mk_nxt = PTR_W'(in_i.position);
            ok     = 1'b1;
          end
        end
        REQ_RESTORE: begin
          rp_nxt = mk_r;
          ok     = 1'b1;
        end
        REQ_RECOVER: begin
          rp_nxt = '0;
          mk_nxt = '0;
          ok     = 1'b1;
        end
        REQ_CLEAR: begin
          wp_nxt    = '0;
          rp_nxt    = '0;
          mk_nxt    = '0;
          full_nxt  = 1'b0;
          end_nxt   = 1'b0;
          empty_nxt = 1'b1;
          ok        = 1'b1;
        end
        REQ_PEEK: begin
          if ((pos32 < wp32) && (pos32 < 32'(MEM_DEPTH))) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = ADDR_W'(in_i.position);
            byte_sel_o  = 1'b1;
            ok          = 1'b1;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
    if (cfg_i.wr) begin
      case (cfg_i.index)
        CFG_INIT_CAP:  cap_nxt  = cap_cfg;
        CFG_GROW_STEP: step_nxt = cfg_i.data[7:0];
        CFG_GROW_MODE: mode_nxt = cfg_i.data[1:0];
        default:       step_nxt = step_r;
      endcase
    end
  end

  assign mem_waddr_o = wp_r[ADDR_W-1:0];
  assign mem_wdata_o = in_i.data_byte;

  assign wpo32  = 32'(wp_nxt);
  assign rpo32  = 32'(rp_nxt);
  assign mko32  = 32'(mk_nxt);
  assign capo32 = 32'(cap_nxt);

  always_comb begin
    res_o.ok           = ok;
    res_o.read_byte    = 8'd0;
    res_o.at_end       = end_nxt;
    res_o.is_full      = full_nxt;
    res_o.is_empty     = empty_nxt;
    res_o.write_index  = wpo32[12:0];
    res_o.read_index   = rpo32[12:0];
    res_o.mark_index   = mko32[12:0];
    res_o.capacity_now = capo32[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      mk_r    <= '0;
      cap_r   <= PTR_W'(CAP_RST);
      full_r  <= 1'b0;
      empty_r <= 1'b1;
      end_r   <= 1'b0;
      step_r  <= STEP_RESET;
      mode_r  <= MODE_RESET;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      mk_r    <= mk_nxt;
      cap_r   <= cap_nxt;
      full_r  <= full_nxt;
      empty_r <= empty_nxt;
      end_r   <= end_nxt;
      step_r  <= step_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // The read pointer and the mark never pass the write pointer.
  a_rp_le_wp: assert property (@(posedge clk) disable iff (!rst_n) rp_r <= wp_r)
    else $error("read pointer beyond write pointer");
  a_mk_le_wp: assert property (@(posedge clk) disable iff (!rst_n) mk_r <= wp_r)
    else $error("mark beyond write pointer");
  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (32'(cap_r) <= 32'(MEM_DEPTH)))
    else $error("capacity out of range");

endmodule

`default_nettype wire

// ===== src/lexer_input_buffer_with_mark.sv =====
// Top level of the lexer input buffer: byte store, request handshake and result stages.
// A result is held in stage A once its request is accepted, then in the output register.
// Throughput: one request per cycle unless the output stalls, set by the single-port write
// and registered read of the byte store and the registered pointer update.
// Reset: synchronous, active low; pointers clear, empty sets, the other flags clear,
// capacity 256 (held to store depth), step 16, additive mode; the byte store is not cleared.
`default_nettype none

module lexer_input_buffer_with_mark #(
  parameter int MEM_DEPTH = lbm_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lbm_pkg::lbm_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lbm_pkg::lbm_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [12:0]       cfg_data
);
  import lbm_pkg::*;

  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // The request is handled in the cycle it is accepted: the controller updates its
  // pointers and may write the store or issue a registered read. Stage A then
  // holds the result fields alongside the store's read data; stage B is the output
  // register. Two stages let a new request in while a finished result is stalled.
  logic              in_acc;
  lbm_cfg_t          cfg;
  lbm_out_t          res;
  logic              byte_sel;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] mem_q_r;

  logic     a_valid_r, a_valid_nxt, a_sel_r;
  lbm_out_t a_res_r;
  logic     b_valid_r, b_valid_nxt;
  lbm_out_t b_res_r, b_res_nxt;
  logic     a_move;

  // The port never pushes back; writes must arrive only while idle (not enforced).
  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Stage A passes its result on when the output register is free or is being taken.
  assign a_move   = a_valid_r && (!b_valid_r || !out_stall);
  assign in_stall = a_valid_r && !a_move;
  assign in_acc   = in_valid && !in_stall;

  lbm_ctrl #(
    .MEM_DEPTH (MEM_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_i       (in_acc),
    .in_i        (in_data),
    .cfg_i       (cfg),
    .res_o       (res),
    .byte_sel_o  (byte_sel),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  // Byte store. The read register only loads on an accepted read or peek, so its data stays
  // with the request in stage A until that request moves on.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end

    b_valid_nxt = b_valid_r;
    if (a_move) begin
      b_valid_nxt = 1'b1;
    end else if (b_valid_r && !out_stall) begin
      b_valid_nxt = 1'b0;
    end

    // The store's byte is merged in only for a successful read or peek.
    b_res_nxt           = a_res_r;
    b_res_nxt.read_byte = a_sel_r ? mem_q_r : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_res_r <= res;
      a_sel_r <= byte_sel;
    end
    if (a_move) begin
      b_res_r <= b_res_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_res_r;

  // A byte is only ever returned by a request that succeeded.
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.read_byte == 8'd0) || out_data.ok))
    else $error("byte returned by a rejected request");
  // The full flag can only be raised once something has been stored.
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_full && out_data.is_empty))
    else $error("buffer reported both full and empty");
  // Stage A never drops a request: once loaded it moves on or holds.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !a_move) |=> a_valid_r)
    else $error("stalled request lost from stage A");

endmodule

`default_nettype wire

// ===== test/lbm_checker.sv =====
// Checker for the lexer input buffer: predicts every result and compares it field by field.
`timescale 1ns / 100ps

module lbm_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  lbm_pkg::lbm_in_t in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  lbm_pkg::lbm_out_t out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [12:0]      cfg_data,
  output int               mismatches,
  output int               pending
);
  import lbm_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;

  // Shadow copy of the buffer state and its settings.
  logic [7:0]  shadow_bytes [0:DEPTH-1];
  int unsigned wr_ptr, rd_ptr, mark_pos, cap_now, step_amt;
  logic [1:0]  mode_sel;
  bit          full_f, empty_f, end_f;

  lbm_out_t expected_results [$];
  int       mismatch_total = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic int unsigned clamp_capacity(int unsigned v);
    if (v == 0) return 1;
    if (v > DEPTH) return DEPTH;
    return v;
  endfunction

  task automatic predict_request(input lbm_in_t rq, output lbm_out_t res);
    int unsigned grown;
    bit          ok;
    logic [7:0]  rb;
    ok = 1'b0;
    rb = 8'd0;
    case (lbm_req_t'(rq.req_type))
      REQ_ADD: begin
        ok = 1'b1;
        if (wr_ptr < cap_now) begin
          full_f = 1'b0;
        end else begin
          // Capacity reached: try to grow; fixed and unused modes leave grown at zero.
          full_f = 1'b1;
          grown  = 0;
          if (mode_sel == MODE_ADD) grown = cap_now + step_amt;
          else if (mode_sel == MODE_MUL) grown = cap_now * step_amt;
          if (wr_ptr >= DEPTH || step_amt == 0 || grown <= cap_now || grown > DEPTH) ok = 1'b0;
          else cap_now = grown;
        end
        if (wr_ptr >= DEPTH) ok = 1'b0;
        if (ok) begin
          empty_f = 1'b0;
          shadow_bytes[wr_ptr] = rq.data_byte;
          wr_ptr++;
        end
      end
      REQ_READ: begin
        if (rd_ptr == wr_ptr || rd_ptr >= DEPTH) begin
          end_f = 1'b1;
        end else begin
          end_f = 1'b0;
          rb = shadow_bytes[rd_ptr];
          rd_ptr++;
          ok = 1'b1;
        end
      end
      REQ_RETRACT: begin
        if (rd_ptr != 0) begin
          rd_ptr--;
          ok = 1'b1;
        end
      end
      REQ_MARK: begin
        if (rq.position <= wr_ptr) begin
          mark_pos = 32'(rq.position);
          ok = 1'b1;
        end
      end
      REQ_RESTORE: begin
        rd_ptr = mark_pos;
        ok = 1'b1;
      end
      REQ_RECOVER: begin
        rd_ptr   = 0;
        mark_pos = 0;
        ok = 1'b1;
      end
      REQ_CLEAR: begin
        wr_ptr   = 0;
        rd_ptr   = 0;
        mark_pos = 0;
        full_f   = 1'b0;
        end_f    = 1'b0;
        empty_f  = 1'b1;
        ok = 1'b1;
      end
      default: begin
        if (rq.position < wr_ptr && rq.position < DEPTH) begin
          rb = shadow_bytes[rq.position];
          ok = 1'b1;
        end
      end
    endcase
    res.ok           = ok;
    res.read_byte    = rb;
    res.at_end       = end_f;
    res.is_full      = full_f;
    res.is_empty     = empty_f;
    res.write_index  = wr_ptr[12:0];
    res.read_index   = rd_ptr[12:0];
    res.mark_index   = mark_pos[12:0];
    res.capacity_now = cap_now[12:0];
  endtask

  task automatic compare_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
    if (got !== want) begin
      if (mismatch_total < 10)
        $display("%0t: %s differs: expected %0d, got %0d", $realtime, name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    lbm_out_t want;
    lbm_out_t made;
    if (!rst_n) begin
      wr_ptr   = 0;
      rd_ptr   = 0;
      mark_pos = 0;
      step_amt = 32'(STEP_RESET);
      mode_sel = MODE_RESET;
      cap_now  = clamp_capacity(CAP_RESET);
      full_f   = 1'b0;
      empty_f  = 1'b1;
      end_f    = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INIT_CAP:  cap_now  = clamp_capacity(32'(cfg_data));
          CFG_GROW_STEP: step_amt = 32'(cfg_data[7:0]);
          CFG_GROW_MODE: mode_sel = cfg_data[1:0];
          default: ;
        endcase
      end
      // Results leave before new requests are predicted, so a result can never
      // be matched against the request accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: result arrived with nothing expected", $realtime);
          mismatch_total++;
        end else begin
          want = expected_results.pop_front();
          compare_field("ok",           13'(want.ok),        13'(out_data.ok));
          compare_field("read_byte",    13'(want.read_byte), 13'(out_data.read_byte));
          compare_field("at_end",       13'(want.at_end),    13'(out_data.at_end));
          compare_field("is_full",      13'(want.is_full),   13'(out_data.is_full));
          compare_field("is_empty",     13'(want.is_empty),  13'(out_data.is_empty));
          compare_field("write_index",  want.write_index,    out_data.write_index);
          compare_field("read_index",   want.read_index,     out_data.read_index);
          compare_field("mark_index",   want.mark_index,     out_data.mark_index);
          compare_field("capacity_now", want.capacity_now,   out_data.capacity_now);
        end
      end
      if (in_valid && !in_stall) begin
        predict_request(in_data, made);
        expected_results.push_back(made);
      end
    end
    mismatches <= mismatch_total;
    pending    <= expected_results.size();
  end

endmodule

// ===== test/lexer_input_buffer_with_mark_tb.sv =====
// Testbench top for the lexer input buffer: request stimulus, configuration phases and verdict.
`timescale 1ns / 100ps

module lexer_input_buffer_with_mark_tb;
  import lbm_pkg::*;

  // The configuration port has a fourth index that maps to no register; a write
  // to it must leave every setting untouched.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Cycles without any handshake before the run is declared hung. The longest
  // legitimate quiet spell is the deliberate hold-off on the result side.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_REQS  = 135;
  localparam int FILL_CAP    = 600;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  wire         in_stall;
  lbm_in_t     in_data = '0;
  wire         out_valid;
  logic        out_stall = 1'b0;
  lbm_out_t    out_data;
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  int mismatches;
  int pending;
  int quiet_cycles = 0;

  // calm switches random idling off on both sides; squeeze asks the result
  // side for one long hold-off.
  bit calm = 1'b0;
  bit squeeze = 1'b0;

  // Settings for the random phases: capacity, step and growth mode. Between
  // them they reach both ends of the capacity and step registers, a capacity
  // beyond the store, the spare mode code, a zero step and a multiplier that
  // cannot grow the capacity.
  logic [12:0] cap_tab  [8] = '{13'd8, 13'd1, 13'd16, 13'd5, 13'd12, 13'h1FFF, 13'd0, 13'd3};
  logic [7:0]  step_tab [8] = '{8'd4, 8'd2, 8'd0, 8'd3, 8'd255, 8'd255, 8'd1, 8'd1};
  logic [1:0]  mode_tab [8] = '{MODE_ADD, MODE_MUL, MODE_ADD, MODE_SPARE,
                                MODE_MUL, MODE_ADD, MODE_ADD, MODE_MUL};

  lexer_input_buffer_with_mark uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lbm_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side. Every edge it decides afresh whether to stall, except when a
  // hold-off has been asked for: then it holds the stall long enough that the
  // block fills up and has to stall its own input.
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 31);
      end
    end
  end

  // Watchdog: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic lbm_in_t make_request(lbm_req_t kind, logic [7:0] b, logic [12:0] pos);
    lbm_in_t rq;
    rq.req_type  = kind;
    rq.data_byte = b;
    rq.position  = pos;
    return rq;
  endfunction

  // Lexer-like traffic: mostly appends and reads, with marks, retracts and
  // peeks sprinkled in. Clears are kept rare so that the buffer actually gets
  // to its capacity. Positions mostly fall near the data held; now and then
  // one spans the whole field so that out-of-range marks and peeks occur.
  function automatic lbm_in_t random_request();
    int       roll;
    lbm_req_t kind;
    logic [12:0] pos;
    roll = $urandom_range(99);
    if (roll < 35)      kind = REQ_ADD;
    else if (roll < 60) kind = REQ_READ;
    else if (roll < 68) kind = REQ_RETRACT;
    else if (roll < 76) kind = REQ_MARK;
    else if (roll < 82) kind = REQ_RESTORE;
    else if (roll < 85) kind = REQ_RECOVER;
    else if (roll < 88) kind = REQ_CLEAR;
    else                kind = REQ_PEEK;
    if ($urandom_range(99) < 80) pos = 13'($urandom_range(0, 63));
    else pos = 13'($urandom_range(0, 8191));
    return make_request(kind, 8'($urandom_range(0, 255)), pos);
  endfunction

  // Offers one request and returns at the edge that accepts it. Valid is only
  // dropped for random idle cycles, never lowered and raised in one step.
  task automatic send_request(input lbm_in_t rq);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every predicted result has come back, then lets the block's
  // pipeline settle before anything is reconfigured.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [12:0] cap, input logic [7:0] step,
                           input logic [1:0] mode);
    write_reg(CFG_INIT_CAP, cap);
    write_reg(CFG_GROW_STEP, {5'd0, step});
    write_reg(CFG_GROW_MODE, {11'd0, mode});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests on the reset settings: reads, retracts, peeks and marks
    // on an empty buffer, the extreme byte values, marks and peeks on both sides
    // of the write pointer, and a read that runs into the end of the data.
    send_request(make_request(REQ_READ,    8'd0,   13'd0));
    send_request(make_request(REQ_RETRACT, 8'd0,   13'd0));
    send_request(make_request(REQ_PEEK,    8'd0,   13'd0));
    send_request(make_request(REQ_MARK,    8'd0,   13'd1));
    send_request(make_request(REQ_MARK,    8'd0,   13'd0));
    send_request(make_request(REQ_ADD,     8'h00,  13'd0));
    send_request(make_request(REQ_ADD,     8'hFF,  13'h1FFF));
    send_request(make_request(REQ_ADD,     8'hA5,  13'd0));
    send_request(make_request(REQ_PEEK,    8'd0,   13'd1));
    send_request(make_request(REQ_PEEK,    8'd0,   13'd3));
    send_request(make_request(REQ_PEEK,    8'hFF,  13'h1FFF));
    send_request(make_request(REQ_READ,    8'd0,   13'd0));
    send_request(make_request(REQ_READ,    8'd0,   13'd0));
    send_request(make_request(REQ_MARK,    8'd0,   13'd3));
    send_request(make_request(REQ_MARK,    8'd0,   13'h1FFF));
    send_request(make_request(REQ_MARK,    8'd0,   13'd1));
    send_request(make_request(REQ_RETRACT, 8'd0,   13'd0));
    send_request(make_request(REQ_RESTORE, 8'd0,   13'd0));
    send_request(make_request(REQ_READ,    8'd0,   13'd0));
    send_request(make_request(REQ_READ,    8'd0,   13'd0));
    send_request(make_request(REQ_READ,    8'd0,   13'd0));
    send_request(make_request(REQ_RECOVER, 8'd0,   13'd0));
    send_request(make_request(REQ_CLEAR,   8'd0,   13'd0));
    send_request(make_request(REQ_READ,    8'd0,   13'd0));
    drain();

    // A write to the unused index must change nothing; the first random phase
    // then runs on top of whatever settings follow.
    write_reg(CFG_UNUSED, 13'h1FFF);
    cfg_valid <= 1'b0;
    @(posedge clk);

    // Random phases, one per setting. The first one opens with the long
    // hold-off on the result side while requests keep coming.
    for (int ph = 0; ph < 8; ph++) begin
      configure(cap_tab[ph], step_tab[ph], mode_tab[ph]);
      if (ph == 0) squeeze = 1'b1;
      for (int n = 0; n < PHASE_REQS; n++)
        send_request(random_request());
      drain();
    end

    // Fill a fixed capacity with no idling on either side. The last append
    // finds the capacity reached with growth switched off and is refused; the
    // peeks and reads that follow use positions drawn from the whole field.
    calm = 1'b1;
    configure(13'(FILL_CAP), 8'd200, MODE_NOGROW);
    send_request(make_request(REQ_CLEAR, 8'd0, 13'd0));
    for (int n = 0; n <= FILL_CAP; n++)
      send_request(make_request(REQ_ADD, 8'($urandom_range(0, 255)), 13'd0));
    for (int n = 0; n < 40; n++)
      send_request(make_request($urandom_range(0, 1) ? REQ_PEEK : REQ_READ,
                                8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191))));
    drain();
    calm = 1'b0;

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
